### rtl/min_plus_counter_strategy_top_assert.svh
// Assertion macros for the min-plus counter-strategy block.
// Used by the top level only; no other dependencies.
`ifndef MIN_PLUS_COUNTER_STRATEGY_TOP_ASSERT_SVH
`define MIN_PLUS_COUNTER_STRATEGY_TOP_ASSERT_SVH
`ifndef SYNTH
`define MPCS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpcs assertion failed");
`define MPCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpcs assertion failed");
`else
`define MPCS_ASSERT_IMPLY(label, ante, cons)
`define MPCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/mpcs_pkg.sv
// Shared types and constants of the min-plus counter-strategy block.
// No dependencies.
package mpcs_pkg;

  localparam int NODES_DEF       = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 48;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Item kinds; the last code is unused and the block ignores it.
  localparam logic [1:0] KIND_EDGE   = 2'd0;
  localparam logic [1:0] KIND_CHOICE = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER   = 2'd1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         source_node;
    logic [5:0]         dest_node;
    logic signed [15:0] edge_weight;
    logic               edge_present;
  } in_t;

  typedef struct packed {
    logic [5:0]         node_index;
    logic signed [47:0] node_value;
    logic               value_infinite;
    logic [5:0]         counter_move;
    logic               has_move;
    logic               converged;
    logic               last;
  } out_t;

  // Control shared by every cell of the value ring.
  typedef struct packed {
    logic clear;
    logic shift;
    logic copy;
  } cell_ctrl_t;

endpackage

### rtl/mpcs_cell.sv
// One cell of the value ring: holds the current and next value of one node.
// Depends on mpcs_pkg.
module mpcs_cell #(
  parameter int VALUE_BITS = mpcs_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpcs_pkg::cell_ctrl_t         ctrl,
  input  logic                         active,
  input  logic                         wr_en,
  input  logic signed [VALUE_BITS-1:0] wr_val,
  input  logic                         wr_inf,
  input  logic signed [VALUE_BITS-1:0] nb_val,
  input  logic                         nb_inf,
  output logic signed [VALUE_BITS-1:0] cur_val,
  output logic                         cur_inf,
  output logic                         diff
);

  logic signed [VALUE_BITS-1:0] cur_val_r, cur_val_nxt, vnext_val_r;
  logic                         cur_inf_r, cur_inf_nxt, vnext_inf_r;

  // Current value: cleared at run start, rotated during sweeps, updated at round end.
  always_comb begin
    cur_val_nxt = cur_val_r;
    cur_inf_nxt = cur_inf_r;
    if (ctrl.clear) begin
      cur_val_nxt = '0;
      cur_inf_nxt = 1'b0;
    end else if (ctrl.shift) begin
      cur_val_nxt = nb_val;
      cur_inf_nxt = nb_inf;
    end else if (ctrl.copy && active) begin
      cur_val_nxt = vnext_val_r;
      cur_inf_nxt = vnext_inf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_val_r <= '0;
      cur_inf_r <= 1'b0;
    end else begin
      cur_val_r <= cur_val_nxt;
      cur_inf_r <= cur_inf_nxt;
    end
  end

  // The next value is written once per round by the evaluator.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vnext_val_r <= wr_val;
      vnext_inf_r <= wr_inf;
    end
  end

  assign cur_val = cur_val_r;
  assign cur_inf = cur_inf_r;
  assign diff = active && ((vnext_inf_r != cur_inf_r) ||
                           (!cur_inf_r && (vnext_val_r != cur_val_r)));

endmodule

### rtl/mpcs_wmem.sv
// Edge memory: one word per node pair holding a valid flag and a weight.
// Cleared by a sweep after reset. Depends on mpcs_pkg for defaults.
module mpcs_wmem #(
  parameter int NODES       = mpcs_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = mpcs_pkg::WEIGHT_BITS_DEF,
  localparam int DEPTH      = NODES * NODES,
  localparam int AB         = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [AB-1:0]                 wr_addr,
  input  logic                          wr_valid,
  input  logic signed [WEIGHT_BITS-1:0] wr_weight,
  input  logic [AB-1:0]                 rd_addr,
  output logic                          rd_valid,
  output logic signed [WEIGHT_BITS-1:0] rd_weight,
  output logic                          clearing
);

  logic [WEIGHT_BITS:0] mem [DEPTH];
  logic [WEIGHT_BITS:0] rd_q_r;
  logic [AB-1:0]        clr_addr_r;
  logic                 clearing_r;
  logic                 we;
  logic [AB-1:0]        wa;
  logic [WEIGHT_BITS:0] wd;

  // Clear sweep walks every entry once after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AB'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Single write port, shared between the clear sweep and edge writes.
  always_comb begin
    we = wr_en;
    wa = wr_addr;
    wd = {wr_valid, wr_weight};
    if (clearing_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_valid  = rd_q_r[WEIGHT_BITS];
  assign rd_weight = signed'(rd_q_r[WEIGHT_BITS-1:0]);
  assign clearing  = clearing_r;

endmodule

### rtl/min_plus_counter_strategy_top.sv
// Min-plus value iteration against a fixed strategy, with counter-move output.
// Depends on mpcs_pkg, mpcs_cell, mpcs_wmem and the assertion macro header.
//
// Usage: items arrive on in_data and are taken when start is high and busy is
// low. An edge write or a strategy write leaves busy low. A run beat clears all
// values, then repeats rounds until a fixed point or the iteration limit, and
// then emits one result per active node on out_data, each marked by out_valid
// for exactly one cycle; the final one carries last. The receiver cannot stall.
// Each node of a round passes S_CHOICE (a read of the chosen edge), S_SWEEP (all
// NODES destinations swept through the edge memory's single read port while the
// value ring rotates by one cell per cycle) and S_DRAIN; a round also passes
// S_ROUND and S_CHECK. Emission sweeps each active node's row the same way and
// then drains its result. The user is to write configuration through
// cfg_valid/cfg_ready only while busy is low; the block itself does not enforce
// it. After reset the edge memory is cleared entry by entry with busy held high;
// configuration is still taken.
module min_plus_counter_strategy_top #(
  parameter int NODES       = mpcs_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = mpcs_pkg::WEIGHT_BITS_DEF,
  parameter int VALUE_BITS  = mpcs_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  mpcs_pkg::in_t                       in_data,
  output logic                                out_valid,
  output mpcs_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mpcs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mpcs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int NB = $clog2(NODES);
  localparam int CB = $clog2(NODES + 1);
  localparam int AB = $clog2(NODES * NODES);
  localparam int SW = ((VALUE_BITS > WEIGHT_BITS + 1) ? VALUE_BITS : WEIGHT_BITS + 1) + 2;
  localparam logic signed [SW-1:0] VMAX_W = SW'((65'sd1 <<< (VALUE_BITS - 1)) - 65'sd1);
  localparam logic signed [SW-1:0] VMIN_W = -VMAX_W - SW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_CHOICE, S_SWEEP, S_DRAIN, S_CHECK, S_ESWEEP, S_EDRAIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [6:0]  node_count_r;
  logic [15:0] max_iter_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'd16;
      max_iter_r   <= 16'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        mpcs_pkg::REG_NODE_COUNT: node_count_r <= cfg_wdata[6:0];
        mpcs_pkg::REG_MAX_ITER:   max_iter_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control and pipeline registers.
  logic [CB-1:0] n_r;
  logic [NB-1:0] u_r, v_r, p_v_r, mv_r;
  logic [15:0]   rounds_r;
  logic          conv_r;
  logic [5:0]    s_r;
  logic          s_ok_r;
  logic          p_act_r, p_a_r, p_inrange_r;
  logic signed [VALUE_BITS-1:0]  p_head_val_r, best_val_r, ev_val_r;
  logic                          p_head_inf_r, best_inf_r, ev_inf_r, has_r;
  logic signed [WEIGHT_BITS-1:0] a_r;
  logic          out_valid_r;
  mpcs_pkg::out_t out_r;

  logic clearing, accept, emit_mode;
  logic [CB-1:0] n_calc;

  assign busy      = (state_r != S_IDLE) || clearing;
  assign accept    = start && !busy;
  assign emit_mode = (state_r == S_ESWEEP) || (state_r == S_EDRAIN);

  // Active node count, clamped to one through NODES.
  always_comb begin
    if (node_count_r == 7'd0) begin
      n_calc = CB'(1);
    end else if (node_count_r > 7'(NODES)) begin
      n_calc = CB'(NODES);
    end else begin
      n_calc = CB'(node_count_r);
    end
  end

  // Strategy choices, read at the node under evaluation.
  logic [5:0] strat_r [NODES];
  logic [5:0] s_cur;
  logic       s_ok_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        strat_r[i] <= '0;
      end
    end else if (accept && (in_data.kind == mpcs_pkg::KIND_CHOICE) &&
                 (7'(in_data.source_node) < 7'(NODES))) begin
      strat_r[in_data.source_node[NB-1:0]] <= in_data.dest_node;
    end
  end

  assign s_cur    = strat_r[u_r];
  assign s_ok_cur = 7'(s_cur) < 7'(n_r);

  // Edge memory ports.
  logic                          mem_wr_en, rd_valid;
  logic [AB-1:0]                 mem_wr_addr, rd_addr;
  logic signed [WEIGHT_BITS-1:0] rd_weight;
  logic [NB-1:0]                 row_sel;

  assign mem_wr_en = accept && (in_data.kind == mpcs_pkg::KIND_EDGE) &&
                     (7'(in_data.source_node) < 7'(NODES)) &&
                     (7'(in_data.dest_node) < 7'(NODES));
  assign mem_wr_addr = AB'(in_data.source_node[NB-1:0]) * AB'(NODES) +
                       AB'(in_data.dest_node[NB-1:0]);

  always_comb begin
    row_sel = emit_mode ? u_r : (s_ok_r ? s_r[NB-1:0] : '0);
    if (state_r == S_CHOICE) begin
      rd_addr = s_ok_cur ? (AB'(u_r) * AB'(NODES) + AB'(s_cur[NB-1:0])) : '0;
    end else begin
      rd_addr = AB'(row_sel) * AB'(NODES) + AB'(v_r);
    end
  end

  mpcs_wmem #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_wmem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_valid  (in_data.edge_present),
    .wr_weight (WEIGHT_BITS'(in_data.edge_weight)),
    .rd_addr   (rd_addr),
    .rd_valid  (rd_valid),
    .rd_weight (rd_weight),
    .clearing  (clearing)
  );

  // Value ring: cell 0 is the head, each cell takes its upper neighbor on a shift.
  mpcs_pkg::cell_ctrl_t          cell_ctrl;
  logic signed [VALUE_BITS-1:0]  cell_val [NODES];
  logic                          cell_inf [NODES];
  logic                          cell_diff [NODES];
  logic                          any_diff;
  logic signed [VALUE_BITS-1:0]  best_val_nxt;
  logic                          best_inf_nxt, has_nxt;
  logic [NB-1:0]                 mv_nxt;

  always_comb begin
    cell_ctrl.clear = accept && (in_data.kind == mpcs_pkg::KIND_RUN);
    cell_ctrl.shift = (state_r == S_SWEEP) || (state_r == S_ESWEEP);
    cell_ctrl.copy  = (state_r == S_CHECK) && any_diff;
  end

  for (genvar gi = 0; gi < NODES; gi++) begin : g_cell
    mpcs_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cell_ctrl),
      .active  (CB'(gi) < n_r),
      .wr_en   ((state_r == S_DRAIN) && (u_r == NB'(gi))),
      .wr_val  (best_val_nxt),
      .wr_inf  (best_inf_nxt),
      .nb_val  (cell_val[(gi + 1) % NODES]),
      .nb_inf  (cell_inf[(gi + 1) % NODES]),
      .cur_val (cell_val[gi]),
      .cur_inf (cell_inf[gi]),
      .diff    (cell_diff[gi])
    );
  end

  always_comb begin
    any_diff = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      any_diff = any_diff | cell_diff[i];
    end
  end

  // Evaluator stage: saturating add of value and weights, then the running minimum.
  logic signed [WEIGHT_BITS-1:0] a_eff;
  logic signed [SW-1:0]          sum_w;
  logic signed [VALUE_BITS-1:0]  c_val;
  logic                          cand, c_less, upd;

  always_comb begin
    a_eff = emit_mode ? '0 : a_r;
    sum_w = SW'(p_head_val_r) + SW'(a_eff) + SW'(rd_weight);
    if (sum_w > VMAX_W) begin
      c_val = VALUE_BITS'(VMAX_W);
    end else if (sum_w < VMIN_W) begin
      c_val = VALUE_BITS'(VMIN_W);
    end else begin
      c_val = VALUE_BITS'(sum_w);
    end
    cand   = p_act_r && p_inrange_r && rd_valid && (emit_mode || s_ok_r);
    c_less = !p_head_inf_r && (best_inf_r || (c_val < best_val_r));
    upd    = cand && (emit_mode ? (!has_r || c_less) : c_less);
    best_val_nxt = best_val_r;
    best_inf_nxt = best_inf_r;
    has_nxt      = has_r;
    mv_nxt       = mv_r;
    if (upd) begin
      best_val_nxt = p_head_inf_r ? p_head_val_r : c_val;
      best_inf_nxt = p_head_inf_r;
      has_nxt      = 1'b1;
      mv_nxt       = p_v_r;
    end
  end

  // Value of the emitted node, seen at the head when the sweep passes it.
  logic signed [VALUE_BITS-1:0] emit_val;
  logic                         emit_inf;
  logic [63:0]                  emit_val_z;
  logic                         last_u;

  assign emit_val   = (p_v_r == u_r) ? p_head_val_r : ev_val_r;
  assign emit_inf   = (p_v_r == u_r) ? p_head_inf_r : ev_inf_r;
  assign emit_val_z = 64'(unsigned'(emit_val));
  assign last_u     = CB'(u_r) == CB'(n_r - CB'(1));

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_act_r     <= 1'b0;
      p_a_r       <= 1'b0;
      u_r         <= '0;
      v_r         <= '0;
      rounds_r    <= '0;
      conv_r      <= 1'b0;
      n_r         <= CB'(1);
    end else begin
      out_valid_r <= 1'b0;
      p_a_r       <= 1'b0;
      p_act_r     <= 1'b0;
      if (p_a_r) begin
        a_r <= rd_valid ? rd_weight : '0;
      end
      if (p_act_r) begin
        best_val_r <= best_val_nxt;
        best_inf_r <= best_inf_nxt;
        has_r      <= has_nxt;
        mv_r       <= mv_nxt;
        if (emit_mode && (p_v_r == u_r)) begin
          ev_val_r <= p_head_val_r;
          ev_inf_r <= p_head_inf_r;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (accept && (in_data.kind == mpcs_pkg::KIND_RUN)) begin
            n_r      <= n_calc;
            rounds_r <= '0;
            conv_r   <= 1'b0;
            state_r  <= S_ROUND;
          end
        end
        S_ROUND: begin
          u_r <= '0;
          v_r <= '0;
          if (rounds_r < max_iter_r) begin
            state_r <= S_CHOICE;
          end else begin
            best_val_r <= '0;
            best_inf_r <= 1'b1;
            has_r      <= 1'b0;
            mv_r       <= '0;
            state_r    <= S_ESWEEP;
          end
        end
        S_CHOICE: begin
          s_r        <= s_cur;
          s_ok_r     <= s_ok_cur;
          p_a_r      <= 1'b1;
          best_val_r <= '0;
          best_inf_r <= 1'b1;
          v_r        <= '0;
          state_r    <= S_SWEEP;
        end
        S_SWEEP, S_ESWEEP: begin
          p_act_r      <= 1'b1;
          p_v_r        <= v_r;
          p_inrange_r  <= CB'(v_r) < n_r;
          p_head_val_r <= cell_val[0];
          p_head_inf_r <= cell_inf[0];
          v_r          <= v_r + 1'b1;
          if (v_r == NB'(NODES - 1)) begin
            state_r <= (state_r == S_SWEEP) ? S_DRAIN : S_EDRAIN;
          end
        end
        S_DRAIN: begin
          if (last_u) begin
            rounds_r <= rounds_r + 16'd1;
            state_r  <= S_CHECK;
          end else begin
            u_r     <= u_r + 1'b1;
            state_r <= S_CHOICE;
          end
        end
        S_CHECK: begin
          if (!any_diff) begin
            conv_r     <= 1'b1;
            u_r        <= '0;
            v_r        <= '0;
            best_val_r <= '0;
            best_inf_r <= 1'b1;
            has_r      <= 1'b0;
            mv_r       <= '0;
            state_r    <= S_ESWEEP;
          end else begin
            state_r <= S_ROUND;
          end
        end
        S_EDRAIN: begin
          out_valid_r          <= 1'b1;
          out_r.node_index     <= 6'(u_r);
          out_r.node_value     <= emit_inf ? '0 : signed'(emit_val_z[47:0]);
          out_r.value_infinite <= emit_inf;
          out_r.counter_move   <= has_nxt ? 6'(mv_nxt) : 6'd0;
          out_r.has_move       <= has_nxt;
          out_r.converged      <= conv_r;
          out_r.last           <= last_u;
          best_val_r <= '0;
          best_inf_r <= 1'b1;
          has_r      <= 1'b0;
          mv_r       <= '0;
          v_r        <= '0;
          if (last_u) begin
            state_r <= S_IDLE;
          end else begin
            u_r     <= u_r + 1'b1;
            state_r <= S_ESWEEP;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on sequencing between the input and result channels.
`include "min_plus_counter_strategy_top_assert.svh"
  `MPCS_ASSERT_IMPLY(a_result_while_busy, out_valid, $past(busy))
  `MPCS_ASSERT_NEXT(a_run_goes_busy, accept && (in_data.kind == mpcs_pkg::KIND_RUN), busy)
  `MPCS_ASSERT_NEXT(a_write_stays_idle, accept && (in_data.kind != mpcs_pkg::KIND_RUN), !busy)
  `MPCS_ASSERT_IMPLY(a_last_ends_run, out_valid && out_data.last, !busy)

endmodule
